/* design/ole_pkg.sv */
// Shared types, codes and width constants for the ordered list engine.
package ole_pkg;

    localparam int CAPACITY_DEF     = 64;
    localparam int PAYLOAD_BITS_DEF = 64;
    localparam int KEY_BITS_DEF     = 32;

    localparam int KIND_W    = 4;
    localparam int STATUS_W  = 3;
    localparam int POS_W     = 7;
    localparam int TOTAL_W   = 7;
    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 64;

    // Widest index and count over the whole capacity range.
    localparam int IDX_MAX_W = 10;
    localparam int CNT_MAX_W = 11;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 4'd0,
        K_PUSH_BACK  = 4'd1,
        K_INSERT_AT  = 4'd2,
        K_POP_FRONT  = 4'd3,
        K_POP_BACK   = 4'd4,
        K_ERASE_AT   = 4'd5,
        K_READ_AT    = 4'd6,
        K_FIND_KEY   = 4'd7,
        K_FRONT      = 4'd8,
        K_BACK       = 4'd9
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_RANGE   = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_MISSING = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_ERASE  = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic [IDX_MAX_W-1:0]   idx;
    } t_cell_ctl;

    typedef struct packed {
        logic                   active;
        logic                   done;
        logic                   find;
        logic [IDX_MAX_W-1:0]   target;
        logic [CNT_MAX_W-1:0]   limit;
        logic [KEY_W-1:0]       key;
        logic [KEY_W-1:0]       hit_key;
        logic [PAYLOAD_W-1:0]   hit_payload;
        logic [CNT_MAX_W-1:0]   hit_pos;
    } t_probe;

endpackage

/* design/ordered_list_engine_top.sv */
// Top level of the ordered list engine: request decode, record count, cell chain and result register.
// Inserts, pops, erases and every failed request give their result in the cycle after acceptance,
// and such requests can be accepted in every cycle while the output side takes each result.
// Read, find, front and back send a probe down the cell chain, one cell per cycle, so their result
// is registered once the probe reaches the chain end and the output is free, and no request is taken before.
// Reset clears the record count and the probe chain; record storage is left uninitialized.
module ordered_list_engine_top #(
    parameter int CAPACITY     = ole_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_BITS = ole_pkg::PAYLOAD_BITS_DEF,
    parameter int KEY_BITS     = ole_pkg::KEY_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [3:0]    i_s_tuser,   // kind
    input  logic [103:0]  i_s_tdata,   // position, key, payload
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [2:0]    o_m_tuser,   // status
    output logic [111:0]  o_m_tdata    // found_key, found_payload, found_position, entry_total
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int IW  = $clog2(CAPACITY);
    localparam int PCW = ((CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W) + 1;
    localparam int XIW = ole_pkg::IDX_MAX_W;
    localparam int XCW = ole_pkg::CNT_MAX_W;
    localparam int KW  = ole_pkg::KEY_W;
    localparam int PW  = ole_pkg::PAYLOAD_W;
    localparam int SW  = ole_pkg::STATUS_W;
    localparam int OPW = ole_pkg::POS_W;
    localparam int TW  = ole_pkg::TOTAL_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_WAIT  = 3'b100
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;

    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [SW-1:0]          r_out_status;
    logic [SW-1:0]          n_out_status;
    logic [KW-1:0]          r_out_key;
    logic [KW-1:0]          n_out_key;
    logic [PW-1:0]          r_out_payload;
    logic [PW-1:0]          n_out_payload;
    logic [OPW-1:0]         r_out_pos;
    logic [OPW-1:0]         n_out_pos;
    logic [TW-1:0]          r_out_total;
    logic [TW-1:0]          n_out_total;

    ole_pkg::t_kind         w_kind;
    logic [OPW-1:0]         w_pos;
    logic [KW-1:0]          w_key;
    logic [PW-1:0]          w_payload;
    logic [PCW-1:0]         w_pos_x;
    logic [PCW-1:0]         w_cnt_x;
    logic                   w_empty;
    logic                   w_full;
    logic                   w_ins_range;
    logic                   w_rd_range;
    logic                   w_in_acc;
    logic                   w_out_free;

    ole_pkg::t_status       w_status;
    ole_pkg::t_cell_op      w_op;
    logic [IW-1:0]          w_idx;
    logic                   w_sweep;
    logic                   w_find;
    logic                   w_grow;
    logic                   w_shrink;

    ole_pkg::t_cell_ctl     w_ctl;
    ole_pkg::t_probe        w_launch;
    ole_pkg::t_probe        w_last;
    logic                   w_shift;

    logic [KEY_BITS-1:0]     w_cell_key [CAPACITY];
    logic [PAYLOAD_BITS-1:0] w_cell_payload [CAPACITY];
    ole_pkg::t_probe         w_probe [CAPACITY];

    assign w_kind    = ole_pkg::t_kind'(i_s_tuser);
    assign w_pos     = i_s_tdata[6:0];
    assign w_key     = i_s_tdata[38:7];
    assign w_payload = i_s_tdata[102:39];

    assign w_pos_x     = PCW'(w_pos);
    assign w_cnt_x     = PCW'(r_count);
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count >= CW'(CAPACITY));
    assign w_ins_range = (w_pos_x == '0) || (w_pos_x > (w_cnt_x + PCW'(1)));
    assign w_rd_range  = (w_pos_x == '0) || (w_pos_x > w_cnt_x);

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    always_comb begin
        w_status = ole_pkg::ST_OK;
        w_op     = ole_pkg::OP_HOLD;
        w_idx    = '0;
        w_sweep  = 1'b0;
        w_find   = 1'b0;
        w_grow   = 1'b0;
        w_shrink = 1'b0;
        case (w_kind)
            ole_pkg::K_PUSH_FRONT, ole_pkg::K_PUSH_BACK, ole_pkg::K_INSERT_AT: begin
                if ((w_kind == ole_pkg::K_INSERT_AT) && w_ins_range) begin
                    w_status = ole_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_status = ole_pkg::ST_FULL;
                end else begin
                    w_op   = ole_pkg::OP_INSERT;
                    w_grow = 1'b1;
                    if (w_kind == ole_pkg::K_PUSH_FRONT) begin
                        w_idx = '0;
                    end else if (w_kind == ole_pkg::K_PUSH_BACK) begin
                        w_idx = IW'(r_count);
                    end else begin
                        w_idx = IW'(w_pos_x - PCW'(1));
                    end
                end
            end
            ole_pkg::K_POP_FRONT, ole_pkg::K_POP_BACK: begin
                if (w_empty) begin
                    w_status = ole_pkg::ST_EMPTY;
                end else begin
                    w_op     = ole_pkg::OP_ERASE;
                    w_shrink = 1'b1;
                    w_idx    = (w_kind == ole_pkg::K_POP_FRONT) ? '0
                                                                 : IW'(r_count - CW'(1));
                end
            end
            ole_pkg::K_ERASE_AT, ole_pkg::K_READ_AT: begin
                if (w_empty) begin
                    w_status = ole_pkg::ST_EMPTY;
                end else if (w_rd_range) begin
                    w_status = ole_pkg::ST_RANGE;
                end else begin
                    w_idx = IW'(w_pos_x - PCW'(1));
                    if (w_kind == ole_pkg::K_ERASE_AT) begin
                        w_op     = ole_pkg::OP_ERASE;
                        w_shrink = 1'b1;
                    end else begin
                        w_sweep = 1'b1;
                    end
                end
            end
            ole_pkg::K_FIND_KEY: begin
                if (w_empty) begin
                    w_status = ole_pkg::ST_EMPTY;
                end else begin
                    w_sweep = 1'b1;
                    w_find  = 1'b1;
                end
            end
            ole_pkg::K_FRONT, ole_pkg::K_BACK: begin
                if (w_empty) begin
                    w_status = ole_pkg::ST_EMPTY;
                end else begin
                    w_sweep = 1'b1;
                    w_idx   = (w_kind == ole_pkg::K_FRONT) ? '0 : IW'(r_count - CW'(1));
                end
            end
            default: begin
                w_status = ole_pkg::ST_RANGE;
            end
        endcase
    end

    always_comb begin
        w_ctl.op  = w_in_acc ? w_op : ole_pkg::OP_HOLD;
        w_ctl.idx = XIW'(w_idx);
    end

    always_comb begin
        w_launch = '0;
        if (w_in_acc && w_sweep) begin
            w_launch.active = 1'b1;
            w_launch.find   = w_find;
            w_launch.target = XIW'(w_idx);
            w_launch.limit  = XCW'(r_count);
            w_launch.key    = KW'(w_key[KEY_BITS-1:0]);
        end
    end

    assign w_last  = w_probe[CAPACITY-1];
    assign w_shift = (w_in_acc && w_sweep) || ((r_state == S_SWEEP) && !w_last.active);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_BITS-1:0]     w_lk;
        logic [PAYLOAD_BITS-1:0] w_lp;
        logic [KEY_BITS-1:0]     w_rk;
        logic [PAYLOAD_BITS-1:0] w_rp;
        ole_pkg::t_probe         w_pin;

        if (g == 0) begin : g_head
            assign w_lk  = w_cell_key[g];
            assign w_lp  = w_cell_payload[g];
            assign w_pin = w_launch;
        end else begin : g_body
            assign w_lk  = w_cell_key[g-1];
            assign w_lp  = w_cell_payload[g-1];
            assign w_pin = w_probe[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_rk = w_cell_key[g];
            assign w_rp = w_cell_payload[g];
        end else begin : g_mid
            assign w_rk = w_cell_key[g+1];
            assign w_rp = w_cell_payload[g+1];
        end

        ole_cell #(
            .KEY_BITS     (KEY_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS),
            .CELL_INDEX   (g)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctl           (w_ctl),
            .i_new_key       (w_key[KEY_BITS-1:0]),
            .i_new_payload   (w_payload[PAYLOAD_BITS-1:0]),
            .i_left_key      (w_lk),
            .i_left_payload  (w_lp),
            .i_right_key     (w_rk),
            .i_right_payload (w_rp),
            .o_key           (w_cell_key[g]),
            .o_payload       (w_cell_payload[g]),
            .i_shift         (w_shift),
            .i_probe         (w_pin),
            .o_probe         (w_probe[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_in_acc && w_grow) begin
            n_count = r_count + CW'(1);
        end else if (w_in_acc && w_shrink) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_sweep) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (w_last.active) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_key     = r_out_key;
        n_out_payload = r_out_payload;
        n_out_pos     = r_out_pos;
        n_out_total   = r_out_total;
        if (w_in_acc && !w_sweep) begin
            n_out_valid   = 1'b1;
            n_out_status  = w_status;
            n_out_key     = '0;
            n_out_payload = '0;
            n_out_pos     = '0;
            n_out_total   = TW'(n_count);
        end else if ((r_state == S_WAIT) && w_out_free) begin
            n_out_valid   = 1'b1;
            n_out_status  = w_last.done ? ole_pkg::ST_OK : ole_pkg::ST_MISSING;
            n_out_key     = w_last.hit_key;
            n_out_payload = w_last.hit_payload;
            n_out_pos     = OPW'(w_last.hit_pos);
            n_out_total   = TW'(r_count);
        end else if (i_m_tready) begin
            n_out_valid   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status  <= n_out_status;
        r_out_key     <= n_out_key;
        r_out_payload <= n_out_payload;
        r_out_pos     <= n_out_pos;
        r_out_total   <= n_out_total;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {2'b00, r_out_total, r_out_pos, r_out_payload, r_out_key};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("Record count exceeds capacity.");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> (r_count == $past(r_count)))
        else $error("Record count changed without an accepted word.");

    a_wait_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> w_last.active)
        else $error("Result wait state without a probe at the chain end.");

    a_read_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WAIT) && !w_last.find) |-> w_last.done)
        else $error("Positional lookup probe reached the chain end without a hit.");

    a_busy_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_s_tready)
        else $error("Input ready while a lookup is in flight.");

endmodule

/* design/ole_cell.sv */
// One list cell: holds a record, shifts for inserts and erases, and passes the lookup probe on.
module ole_cell #(
    parameter int KEY_BITS     = ole_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = ole_pkg::PAYLOAD_BITS_DEF,
    parameter int CELL_INDEX   = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ole_pkg::t_cell_ctl      i_ctl,
    input  logic [KEY_BITS-1:0]     i_new_key,
    input  logic [PAYLOAD_BITS-1:0] i_new_payload,
    input  logic [KEY_BITS-1:0]     i_left_key,
    input  logic [PAYLOAD_BITS-1:0] i_left_payload,
    input  logic [KEY_BITS-1:0]     i_right_key,
    input  logic [PAYLOAD_BITS-1:0] i_right_payload,
    output logic [KEY_BITS-1:0]     o_key,
    output logic [PAYLOAD_BITS-1:0] o_payload,
    input  logic                    i_shift,
    input  ole_pkg::t_probe         i_probe,
    output ole_pkg::t_probe         o_probe
);

    localparam int IW = ole_pkg::IDX_MAX_W;
    localparam int CW = ole_pkg::CNT_MAX_W;
    localparam int KW = ole_pkg::KEY_W;
    localparam int PW = ole_pkg::PAYLOAD_W;

    logic [KEY_BITS-1:0]     r_key;
    logic [KEY_BITS-1:0]     n_key;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic [PAYLOAD_BITS-1:0] n_payload;
    ole_pkg::t_probe         r_probe;
    ole_pkg::t_probe         n_probe;
    logic                    w_here;
    logic                    w_above;
    logic                    w_valid;
    logic                    w_hit;

    assign w_here  = (i_ctl.idx == IW'(CELL_INDEX));
    assign w_above = (IW'(CELL_INDEX) > i_ctl.idx);

    always_comb begin
        n_key     = r_key;
        n_payload = r_payload;
        case (i_ctl.op)
            ole_pkg::OP_INSERT: begin
                if (w_here) begin
                    n_key     = i_new_key;
                    n_payload = i_new_payload;
                end else if (w_above) begin
                    n_key     = i_left_key;
                    n_payload = i_left_payload;
                end
            end
            ole_pkg::OP_ERASE: begin
                if (w_here || w_above) begin
                    n_key     = i_right_key;
                    n_payload = i_right_payload;
                end
            end
            default: begin
                n_key     = r_key;
                n_payload = r_payload;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
    end

    assign w_valid = (CW'(CELL_INDEX) < i_probe.limit);
    assign w_hit   = i_probe.active && !i_probe.done &&
                     (i_probe.find ? (w_valid && (i_probe.key[KEY_BITS-1:0] == r_key))
                                   : (i_probe.target == IW'(CELL_INDEX)));

    always_comb begin
        n_probe = i_probe;
        if (w_hit) begin
            n_probe.done        = 1'b1;
            n_probe.hit_key     = KW'(signed'(r_key));
            n_probe.hit_payload = PW'(r_payload);
            n_probe.hit_pos     = CW'(CELL_INDEX + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else if (i_shift) begin
            r_probe <= n_probe;
        end
    end

    assign o_key     = r_key;
    assign o_payload = r_payload;
    assign o_probe   = r_probe;

endmodule

/* tb/sv/list_checker.sv */
// Checker for the ordered list engine: watches both stream channels, predicts each result and compares it.
module list_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tready,
    input  logic [3:0]    i_s_tuser,   // kind
    input  logic [103:0]  i_s_tdata,   // position, key, payload
    input  logic          i_m_tvalid,
    input  logic          i_m_tready,
    input  logic [2:0]    i_m_tuser,   // status
    input  logic [111:0]  i_m_tdata,   // found_key, found_payload, found_position, entry_total
    output int            o_mismatches,
    output int            o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAPACITY = ole_pkg::CAPACITY_DEF;

    typedef struct packed {
        ole_pkg::t_status                status;
        logic [ole_pkg::KEY_W-1:0]       key;
        logic [ole_pkg::PAYLOAD_W-1:0]   payload;
        logic [ole_pkg::POS_W-1:0]       pos;
        logic [ole_pkg::TOTAL_W-1:0]     total;
    } t_list_result;

    logic [ole_pkg::KEY_W-1:0]     rec_keys     [LIST_CAPACITY];
    logic [ole_pkg::PAYLOAD_W-1:0] rec_payloads [LIST_CAPACITY];
    int                            rec_count;
    int                            result_index;
    t_list_result                  awaited_results [$];

    function automatic t_list_result apply_request(
        input logic [3:0] kind,
        input logic [ole_pkg::POS_W-1:0] pos,
        input logic [ole_pkg::KEY_W-1:0] key,
        input logic [ole_pkg::PAYLOAD_W-1:0] payload);
        t_list_result res;
        bit           hit;
        int           at;
        int           slot;
        int           i;
        res = '0;
        res.status = ole_pkg::ST_OK;
        hit = 1'b0;
        at = 0;
        slot = 0;
        case (kind)
            ole_pkg::K_PUSH_FRONT, ole_pkg::K_PUSH_BACK, ole_pkg::K_INSERT_AT: begin
                if (kind == ole_pkg::K_INSERT_AT && (pos == 0 || pos > rec_count + 1)) begin
                    res.status = ole_pkg::ST_RANGE;
                end else if (rec_count >= LIST_CAPACITY) begin
                    res.status = ole_pkg::ST_FULL;
                end else begin
                    if (kind == ole_pkg::K_PUSH_FRONT) slot = 0;
                    else if (kind == ole_pkg::K_PUSH_BACK) slot = rec_count;
                    else slot = pos - 1;
                    for (i = rec_count; i > slot; i--) begin
                        rec_keys[i]     = rec_keys[i-1];
                        rec_payloads[i] = rec_payloads[i-1];
                    end
                    rec_keys[slot]     = key;
                    rec_payloads[slot] = payload;
                    rec_count++;
                end
            end
            ole_pkg::K_POP_FRONT, ole_pkg::K_POP_BACK, ole_pkg::K_ERASE_AT: begin
                if (rec_count == 0) begin
                    res.status = ole_pkg::ST_EMPTY;
                end else if (kind == ole_pkg::K_ERASE_AT && (pos == 0 || pos > rec_count)) begin
                    res.status = ole_pkg::ST_RANGE;
                end else begin
                    if (kind == ole_pkg::K_POP_FRONT) slot = 0;
                    else if (kind == ole_pkg::K_POP_BACK) slot = rec_count - 1;
                    else slot = pos - 1;
                    for (i = slot; i + 1 < rec_count; i++) begin
                        rec_keys[i]     = rec_keys[i+1];
                        rec_payloads[i] = rec_payloads[i+1];
                    end
                    rec_count--;
                end
            end
            ole_pkg::K_READ_AT: begin
                if (rec_count == 0) res.status = ole_pkg::ST_EMPTY;
                else if (pos == 0 || pos > rec_count) res.status = ole_pkg::ST_RANGE;
                else begin
                    hit = 1'b1;
                    at = pos;
                end
            end
            ole_pkg::K_FIND_KEY: begin
                if (rec_count == 0) begin
                    res.status = ole_pkg::ST_EMPTY;
                end else begin
                    for (i = 0; i < rec_count && !hit; i++) begin
                        if (rec_keys[i] == key) begin
                            hit = 1'b1;
                            at = i + 1;
                        end
                    end
                    if (!hit) res.status = ole_pkg::ST_MISSING;
                end
            end
            ole_pkg::K_FRONT, ole_pkg::K_BACK: begin
                if (rec_count == 0) res.status = ole_pkg::ST_EMPTY;
                else begin
                    hit = 1'b1;
                    at = (kind == ole_pkg::K_FRONT) ? 1 : rec_count;
                end
            end
            default: res.status = ole_pkg::ST_RANGE;
        endcase
        if (hit) begin
            res.key     = rec_keys[at-1];
            res.payload = rec_payloads[at-1];
            res.pos     = at[ole_pkg::POS_W-1:0];
        end
        res.total = rec_count[ole_pkg::TOTAL_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at result %0d, %s: got %0h, expected %0h",
                 result_index, what, got, want);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin : watch
        t_list_result want;
        t_list_result seen;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                seen.status  = ole_pkg::t_status'(i_m_tuser);
                seen.key     = i_m_tdata[31:0];
                seen.payload = i_m_tdata[95:32];
                seen.pos     = i_m_tdata[102:96];
                seen.total   = i_m_tdata[109:103];
                if (awaited_results.size() == 0) begin
                    report_mismatch("word with no request waiting", i_m_tuser, '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (seen.status != want.status)
                        report_mismatch("status", seen.status, want.status);
                    if (seen.key != want.key)
                        report_mismatch("found_key", seen.key, want.key);
                    if (seen.payload != want.payload)
                        report_mismatch("found_payload", seen.payload, want.payload);
                    if (seen.pos != want.pos)
                        report_mismatch("found_position", seen.pos, want.pos);
                    if (seen.total != want.total)
                        report_mismatch("entry_total", seen.total, want.total);
                end
                result_index++;
            end
            if (i_s_tvalid && i_s_tready)
                awaited_results.push_back(apply_request(i_s_tuser, i_s_tdata[6:0],
                                                        i_s_tdata[38:7], i_s_tdata[102:39]));
        end
        o_pending <= awaited_results.size();
    end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the ordered list engine: clock, reset, request stimulus, result back-pressure and verdict.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIST_CAPACITY  = ole_pkg::CAPACITY_DEF;
    localparam int          RANDOM_ITEMS   = 1725;
    localparam int          IDLE_PCT       = 21;
    localparam int          CYCLE_LIMIT    = 1000000;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          HOLD_AT_ITEM   = 400;
    localparam int          CALM_FROM      = 800;
    localparam int          CALM_TO        = 1100;
    localparam int          MAX_POS        = 65;
    localparam logic [3:0]  KIND_UNUSED_LO = 4'd10;
    localparam logic [3:0]  KIND_UNUSED_HI = 4'd15;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_CHURN} t_mix;

    logic          i_clk      = 1'b0;
    logic          i_rst_n    = 1'b0;
    logic          i_s_tvalid = 1'b0;
    logic          o_s_tready;
    logic [3:0]    i_s_tuser  = '0;
    logic [103:0]  i_s_tdata  = '0;
    logic          o_m_tvalid;
    logic          i_m_tready = 1'b0;
    logic [2:0]    o_m_tuser;
    logic [111:0]  o_m_tdata;

    int            mismatches;
    int            pending;
    bit            calm;
    int            hold_left;
    int            depth_guess;
    int unsigned   cycle_count;

    logic [31:0]   key_pool [8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'h0000_0005, 32'h0000_002A, 32'h55AA_55AA};

    ordered_list_engine_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tuser  (o_m_tuser),
        .o_m_tdata  (o_m_tdata)
    );

    list_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tuser    (i_s_tuser),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tuser    (o_m_tuser),
        .i_m_tdata    (o_m_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The long hold keeps a result waiting on the output so that the engine must stall its request side.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send_request(input logic [3:0] kind, input logic [6:0] pos,
                                input logic [31:0] key, input logic [63:0] payload);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {1'b0, payload, key, pos};
        do @(posedge i_clk); while (!o_s_tready);
        case (kind)
            ole_pkg::K_PUSH_FRONT, ole_pkg::K_PUSH_BACK:
                if (depth_guess < LIST_CAPACITY) depth_guess++;
            ole_pkg::K_INSERT_AT:
                if (pos >= 1 && pos <= depth_guess + 1 && depth_guess < LIST_CAPACITY)
                    depth_guess++;
            ole_pkg::K_POP_FRONT, ole_pkg::K_POP_BACK:
                if (depth_guess > 0) depth_guess--;
            ole_pkg::K_ERASE_AT:
                if (pos >= 1 && pos <= depth_guess) depth_guess--;
            default: ;
        endcase
    endtask

    task automatic wait_drained;
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        logic [3:0]   kind;
        logic [6:0]   pos;
        logic [31:0]  key;
        logic [63:0]  payload;
        t_mix         mix;
        int           add_pct;
        int           del_pct;
        int           roll;
        int           phase_len;
        int           sent;
        int           phase;
        int           n;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(ole_pkg::K_POP_FRONT, 7'd0, '0, '0);
        send_request(ole_pkg::K_POP_BACK, 7'd0, '0, '0);
        send_request(ole_pkg::K_ERASE_AT, 7'd1, '0, '0);
        send_request(ole_pkg::K_READ_AT, 7'd1, '0, '0);
        send_request(ole_pkg::K_FIND_KEY, 7'd0, 32'h0000_0005, '0);
        send_request(ole_pkg::K_FRONT, 7'd0, '0, '0);
        send_request(ole_pkg::K_BACK, 7'd0, '0, '0);
        send_request(ole_pkg::K_INSERT_AT, 7'd0, 32'h0000_0001, 64'h1);
        send_request(ole_pkg::K_INSERT_AT, 7'd2, 32'h0000_0001, 64'h1);
        send_request(ole_pkg::K_INSERT_AT, 7'd1, 32'h8000_0000, '1);
        send_request(ole_pkg::K_PUSH_FRONT, 7'd0, 32'h7FFF_FFFF, '0);
        send_request(ole_pkg::K_PUSH_BACK, 7'd0, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000);
        send_request(ole_pkg::K_PUSH_BACK, 7'd127, 32'h7FFF_FFFF, 64'h1);
        send_request(ole_pkg::K_READ_AT, 7'd0, '0, '0);
        send_request(ole_pkg::K_READ_AT, 7'd65, '0, '0);
        send_request(ole_pkg::K_READ_AT, 7'd3, '0, '0);
        send_request(ole_pkg::K_FIND_KEY, 7'd0, 32'h7FFF_FFFF, '0);
        send_request(ole_pkg::K_FIND_KEY, 7'd0, 32'h0000_1234, '0);
        send_request(ole_pkg::K_FRONT, 7'd0, '0, '0);
        send_request(ole_pkg::K_BACK, 7'd0, '0, '0);
        send_request(ole_pkg::K_ERASE_AT, 7'd0, '0, '0);
        send_request(ole_pkg::K_ERASE_AT, 7'd2, '0, '0);
        send_request(KIND_UNUSED_LO, 7'd1, 32'hFFFF_FFFF, '1);
        send_request(KIND_UNUSED_HI, 7'd64, 32'hFFFF_FFFF, '1);
        send_request(ole_pkg::K_POP_FRONT, 7'd0, '0, '0);
        wait_drained();

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            mix = (phase == 0) ? MIX_GROW : t_mix'($urandom_range(0, 2));
            case (mix)
                MIX_GROW:   begin add_pct = 60; del_pct = 15; end
                MIX_SHRINK: begin add_pct = 15; del_pct = 60; end
                default:    begin add_pct = 35; del_pct = 35; end
            endcase
            phase_len = $urandom_range(60, 140);
            for (n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
                calm = (sent >= CALM_FROM && sent < CALM_TO);
                if (sent == HOLD_AT_ITEM) hold_left = HOLD_CYCLES;
                roll = $urandom_range(0, 99);
                if (roll < add_pct) begin
                    case ($urandom_range(0, 2))
                        0:       kind = ole_pkg::K_PUSH_FRONT;
                        1:       kind = ole_pkg::K_PUSH_BACK;
                        default: kind = ole_pkg::K_INSERT_AT;
                    endcase
                end else if (roll < add_pct + del_pct) begin
                    case ($urandom_range(0, 2))
                        0:       kind = ole_pkg::K_POP_FRONT;
                        1:       kind = ole_pkg::K_POP_BACK;
                        default: kind = ole_pkg::K_ERASE_AT;
                    endcase
                end else if (roll < 95) begin
                    case ($urandom_range(0, 3))
                        0:       kind = ole_pkg::K_READ_AT;
                        1:       kind = ole_pkg::K_FIND_KEY;
                        2:       kind = ole_pkg::K_FRONT;
                        default: kind = ole_pkg::K_BACK;
                    endcase
                end else begin
                    kind = 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
                end
                if ($urandom_range(0, 99) < 85) begin
                    if (kind == ole_pkg::K_INSERT_AT)
                        pos = 7'($urandom_range(1, depth_guess + 1));
                    else
                        pos = 7'($urandom_range(1, (depth_guess > 0) ? depth_guess : 1));
                end else begin
                    pos = 7'($urandom_range(0, MAX_POS));
                end
                if ($urandom_range(0, 99) < 60) key = key_pool[$urandom_range(0, 7)];
                else key = $urandom;
                case ($urandom_range(0, 9))
                    0:       payload = '0;
                    1:       payload = '1;
                    default: payload = {$urandom, $urandom};
                endcase
                send_request(kind, pos, key, payload);
                sent++;
            end
            if ($urandom_range(0, 2) == 0) wait_drained();
            phase++;
        end
        calm = 1'b0;

        wait_drained();
        repeat (LIST_CAPACITY + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/ole_pkg.sv
design/ole_cell.sv
design/ordered_list_engine_top.sv
tb/sv/list_checker.sv
tb/sv/tb.sv
